>>> rtl/core/crc8_framed_sensor_deframer_top_macros.svh
// Assertion macros shared by the deframer RTL
`ifndef CRC8_FRAMED_SENSOR_DEFRAMER_TOP_MACROS_SVH
`define CRC8_FRAMED_SENSOR_DEFRAMER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CFSD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfsd: same-cycle check failed");
// next-cycle implication
`define CFSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfsd: next-cycle check failed");
`else
`define CFSD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define CFSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/cfsd_pkg.sv
// Shared types, constants and the CRC-8 column table for the deframer
`default_nettype none
package cfsd_pkg;

   localparam int WIN_LEN  = 14;
   localparam int CRC_SPAN = 13;
   localparam int CNT_W    = $clog2(WIN_LEN + 1);
   localparam int OUT_W    = 120;

   localparam logic [7:0] CRC_POLY     = 8'h07;
   localparam logic [7:0] CRC_TOP      = 8'h80;
   localparam logic [7:0] MAGIC_RESET  = 8'hA5;
   localparam logic [7:0] SOURCE_RESET = 8'h04;

   localparam int FIFO_DEPTH_DEF = 2;

   // csr register indexes
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAGIC  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SOURCE = 1'd1;

   // payload of one accepted frame
   typedef struct packed {
      logic signed [31:0] longitude;
      logic signed [31:0] latitude;
      logic        [15:0] humidity;
      logic signed [15:0] temperature;
   } frame_type;

   typedef logic [7:0] crc_col_type [CRC_SPAN*8];

   // CRC contribution of every single bit of window bytes 0..12 (the CRC is linear, init 0)
   function automatic crc_col_type crc_col_table();
      crc_col_type tbl;
      logic [7:0]  crc;
      for (int k = 0; k < CRC_SPAN; k++) begin
         for (int j = 0; j < 8; j++) begin
            crc = '0;
            for (int i = 0; i < CRC_SPAN; i++) begin
               if (i == k) begin
                  crc = crc ^ 8'(1 << j);
               end
               for (int b = 0; b < 8; b++) begin
                  if ((crc & CRC_TOP) != 8'h00) begin
                     crc = {crc[6:0], 1'b0} ^ CRC_POLY;
                  end else begin
                     crc = {crc[6:0], 1'b0};
                  end
               end
            end
            tbl[k*8+j] = crc;
         end
      end
      return tbl;
   endfunction

   localparam crc_col_type CRC_COL = crc_col_table();

endpackage
`default_nettype wire

>>> rtl/core/cfsd_front.sv
// Front end: byte window, start-byte scan, CRC check and frame push
`default_nettype none
`include "crc8_framed_sensor_deframer_top_macros.svh"
module cfsd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         magic_byte,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] rx_byte
   output logic                    push_valid,
   input  wire logic               push_ready,
   output cfsd_pkg::frame_type     push_frame
);
   import cfsd_pkg::*;

   logic [7:0]       win_ff [WIN_LEN];
   logic [7:0]       win_in [WIN_LEN];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   logic [7:0]       w [WIN_LEN];
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] cnt_w;
   logic [WIN_LEN-1:0] hit;
   logic [CNT_W-1:0] first_idx;
   logic [CNT_W-1:0] second_idx;
   logic [CNT_W-1:0] shift;
   logic [7:0]       crc_calc;
   logic             full14;
   logic             match;
   logic             accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = push_ready;

   // append position, clamped to the last slot
   assign pos   = (cnt_ff > CNT_W'(WIN_LEN - 1)) ? CNT_W'(WIN_LEN - 1) : cnt_ff;
   assign cnt_w = pos + CNT_W'(1);

   // window with the new byte in place, and start-byte hits
   always_comb begin
      for (int p = 0; p < WIN_LEN; p++) begin
         w[p]   = (CNT_W'(p) == pos) ? req_tdata : win_ff[p];
         hit[p] = (CNT_W'(p) < cnt_w) && (w[p] == magic_byte);
      end
   end

   // first hit anywhere, and first hit past slot zero
   always_comb begin
      first_idx  = cnt_w;
      second_idx = CNT_W'(WIN_LEN);
      for (int p = WIN_LEN - 1; p >= 0; p--) begin
         if (hit[p]) begin
            first_idx = CNT_W'(p);
         end
      end
      for (int p = WIN_LEN - 1; p >= 1; p--) begin
         if (hit[p]) begin
            second_idx = CNT_W'(p);
         end
      end
   end

   // CRC over bytes 0..12 as an xor of per-bit columns
   always_comb begin
      crc_calc = '0;
      for (int k = 0; k < CRC_SPAN; k++) begin
         for (int j = 0; j < 8; j++) begin
            if (w[k][j]) begin
               crc_calc = crc_calc ^ CRC_COL[k*8+j];
            end
         end
      end
   end

   assign full14 = (cnt_w == CNT_W'(WIN_LEN)) && hit[0];
   assign match  = full14 && (crc_calc == w[CRC_SPAN]);

   // on a bad CRC drop the start byte and rescan, else drop the leading junk
   assign shift = full14 ? second_idx : first_idx;

   always_comb begin
      cnt_in = match ? '0 : (cnt_w - shift);
      for (int p = 0; p < WIN_LEN; p++) begin
         win_in[p] = 8'h00;
         for (int s = 0; s < WIN_LEN - p; s++) begin
            if (shift == CNT_W'(s)) begin
               win_in[p] = w[p+s];
            end
         end
      end
   end

   // frame out to the queue
   assign push_valid             = accept && match;
   assign push_frame.temperature = {w[2], w[1]};
   assign push_frame.humidity    = {w[4], w[3]};
   assign push_frame.latitude    = {w[8], w[7], w[6], w[5]};
   assign push_frame.longitude   = {w[12], w[11], w[10], w[9]};

   // window count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

   // window bytes
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int p = 0; p < WIN_LEN; p++) begin
            win_ff[p] <= win_in[p];
         end
      end
   end

   `CFSD_ASSERT_IMPLIES(a_push_on_accept, clock, reset, push_valid, req_tvalid && req_tready)
   `CFSD_ASSERT_NEXT(a_clear_after_frame, clock, reset, push_valid, cnt_ff == '0)
   `CFSD_ASSERT_NEXT(a_grow_by_one, clock, reset, accept && !push_valid, (CNT_W+1)'(cnt_ff) <= (CNT_W+1)'($past(cnt_ff)) + (CNT_W+1)'(1))
   `CFSD_ASSERT_IMPLIES(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(WIN_LEN - 1))

endmodule
`default_nettype wire

>>> rtl/core/cfsd_fifo.sv
// Short frame queue between the front and back ends
`default_nettype none
`include "crc8_framed_sensor_deframer_top_macros.svh"
module cfsd_fifo #(
   parameter int DEPTH = cfsd_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire cfsd_pkg::frame_type push_frame,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output cfsd_pkg::frame_type      pop_frame
);
   import cfsd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   frame_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_QW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_frame  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

   `CFSD_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push_valid, push_ready)
   `CFSD_ASSERT_NEXT(a_fill_up, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + CNT_QW'(1))
   `CFSD_ASSERT_NEXT(a_fill_down, clock, reset, do_pop && !do_push, count_ff == $past(count_ff) - CNT_QW'(1))

endmodule
`default_nettype wire

>>> rtl/core/cfsd_back.sv
// Back end: sequence numbering and the registered response stage
`default_nettype none
module cfsd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [7:0]                source_id,
   input  wire logic                      pop_valid,
   output logic                           pop_ready,
   input  wire cfsd_pkg::frame_type       pop_frame,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // [15:0] sequence_res, [31:16] temperature, [47:32] humidity,
   // [79:48] latitude, [111:80] longitude, [119:112] source
   output logic [cfsd_pkg::OUT_W-1:0]     rsp_tdata
);
   import cfsd_pkg::*;

   logic             valid_ff;
   logic [OUT_W-1:0] data_ff;
   logic [15:0]      seq_ff;
   logic             take;

   assign pop_ready  = !valid_ff || rsp_tready;
   assign take       = pop_valid && pop_ready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   // response valid and sequence count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seq_ff   <= '0;
      end else begin
         if (take) begin
            valid_ff <= 1'b1;
            seq_ff   <= seq_ff + 16'd1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= {source_id, pop_frame.longitude, pop_frame.latitude,
                     pop_frame.humidity, pop_frame.temperature, seq_ff};
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/crc8_framed_sensor_deframer_top.sv
// A good frame enters the frame queue on its CRC byte, then the registered response stage.
// Throughput: one request per cycle; req_tready drops only while the frame queue is full.
// The front end decides each byte combinationally (window scan and 13-byte CRC in parallel).
// Reset (synchronous, active high): empties window, queue and response stage, zeroes the
// frame counter, and loads magic_byte 0xA5 and source_id 4.
`default_nettype none
module crc8_framed_sensor_deframer_top #(
   parameter int FIFO_DEPTH = cfsd_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // [7:0] rx_byte
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [15:0] sequence_res, [31:16] temperature, [47:32] humidity,
   // [79:48] latitude, [111:80] longitude, [119:112] source
   output logic [cfsd_pkg::OUT_W-1:0]            rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [cfsd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [7:0]                       csr_wdata
);
   import cfsd_pkg::*;

   logic [7:0] magic_ff;
   logic [7:0] source_ff;
   logic       push_valid, push_ready;
   logic       pop_valid, pop_ready;
   frame_type  push_frame, pop_frame;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff  <= MAGIC_RESET;
         source_ff <= SOURCE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MAGIC:  magic_ff  <= csr_wdata;
            REG_SOURCE: source_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   cfsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .magic_byte (magic_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame)
   );

   cfsd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame)
   );

   cfsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .source_id  (source_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

>>> test/crc8_framed_sensor_deframer_top_test.sv
// Testbench for the CRC-8 framed sensor deframer: framed byte streams checked against a predictor
`timescale 1ns / 100ps

import cfsd_pkg::*;

// one frame result as it sits on rsp_tdata, lowest field last
typedef struct packed {
   logic [7:0]  source;
   logic [31:0] longitude;
   logic [31:0] latitude;
   logic [15:0] humidity;
   logic [15:0] temperature;
   logic [15:0] seq_no;
} frame_result_type;

// CRC-8/ATM over one byte, MSB first
function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
   logic [7:0] c;
   c = crc_in ^ data;
   for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
   end
   return c;
endfunction

// Deframer predictor plus the queue of frames it expects to see
class frame_scoreboard;
   logic [7:0]       magic;
   logic [7:0]       source;
   logic [7:0]       win [WIN_LEN];
   int unsigned      fill;
   logic [15:0]      frame_count;
   frame_result_type expected_q [$];
   int unsigned      errors;

   function new();
      magic = MAGIC_RESET;
      source = SOURCE_RESET;
      foreach (win[k]) win[k] = 8'h00;
      fill = 0;
      frame_count = '0;
      errors = 0;
   endfunction

   function void set_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [7:0] val);
      case (idx)
         REG_MAGIC: magic = val;
         REG_SOURCE: source = val;
         default: ;
      endcase
   endfunction

   // shift the window left by n bytes
   function void drop_front(input int unsigned n);
      if (n == 0 || n > fill) return;
      for (int k = 0; k + n < fill; k++) win[k] = win[k + n];
      fill = fill - n;
   endfunction

   // one accepted request: append, hunt for magic, check CRC once the window is full
   function void note_byte(input logic [7:0] b);
      int unsigned      i;
      logic [7:0]       crc;
      frame_result_type r;
      if (fill > WIN_LEN - 1) fill = WIN_LEN - 1;
      win[fill] = b;
      fill++;
      for (int pass = 0; pass <= WIN_LEN; pass++) begin
         i = 0;
         while (i < fill && win[i] != magic) i++;
         drop_front(i);
         if (fill < WIN_LEN) return;
         crc = 8'h00;
         for (int k = 0; k < CRC_SPAN; k++) crc = crc8_step(crc, win[k]);
         if (crc != win[CRC_SPAN]) begin
            // bad CRC: drop the start byte and rescan
            drop_front(1);
            continue;
         end
         r.seq_no      = frame_count;
         r.temperature = {win[2], win[1]};
         r.humidity    = {win[4], win[3]};
         r.latitude    = {win[8], win[7], win[6], win[5]};
         r.longitude   = {win[12], win[11], win[10], win[9]};
         r.source      = source;
         expected_q.push_back(r);
         frame_count++;
         fill = 0;
         return;
      end
   endfunction

   function void compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   function void check_result(input logic [OUT_W-1:0] data);
      frame_result_type got;
      frame_result_type want;
      got = data;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected frame result, expected none, got %h", $time, data);
         return;
      end
      want = expected_q.pop_front();
      compare_field("sequence_res", 32'(want.seq_no), 32'(got.seq_no));
      compare_field("temperature", 32'(want.temperature), 32'(got.temperature));
      compare_field("humidity", 32'(want.humidity), 32'(got.humidity));
      compare_field("latitude", want.latitude, got.latitude);
      compare_field("longitude", want.longitude, got.longitude);
      compare_field("source", 32'(want.source), 32'(got.source));
   endfunction
endclass

module crc8_framed_sensor_deframer_top_test;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_W-1:0]      rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [7:0]            csr_wdata = 8'h00;

   frame_scoreboard board = new();

   bit no_gaps = 1'b0;
   bit hold_request = 1'b0;
   int burst_left = 0;
   int bytes_sent = 0;

   crc8_framed_sensor_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // byte with extra weight on the start byte and the extremes
   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 9))
         0: return board.magic;
         1: return 8'h00;
         2: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [95:0] random_body();
      logic [95:0] body;
      for (int k = 0; k < 12; k++) body[8*k +: 8] = random_byte();
      return body;
   endfunction

   // one request; opens a new burst with a random gap when the last one ran out
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (!no_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) == 0) gap = 0;
            else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 25);
            else gap = $urandom_range(1, 5);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_byte(b);
      bytes_sent++;
   endtask

   // start byte, 12 payload bytes, CRC byte (optionally spoiled)
   task automatic send_frame(input logic [95:0] body, input bit corrupt);
      logic [7:0] crc;
      crc = crc8_step(8'h00, board.magic);
      push_byte(board.magic);
      for (int k = 0; k < 12; k++) begin
         crc = crc8_step(crc, body[8*k +: 8]);
         push_byte(body[8*k +: 8]);
      end
      if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
      push_byte(crc);
   endtask

   // mostly good frames, some bad CRCs, cut-off frames and line noise
   task automatic random_traffic(input int n);
      int stop_at;
      int kind;
      stop_at = bytes_sent + n;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_frame(random_body(), 1'b0);
         end else if (kind < 80) begin
            send_frame(random_body(), 1'b1);
         end else if (kind < 88) begin
            push_byte(board.magic);
            repeat ($urandom_range(1, 12)) push_byte(random_byte());
         end else begin
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // receiver holds off while frames keep coming, so the queue fills
   task automatic pressure_burst();
      no_gaps = 1'b1;
      hold_request = 1'b1;
      repeat (8) send_frame(random_body(), 1'b0);
      no_gaps = 1'b0;
   endtask

   // wait for every expected frame plus the pipeline latency
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.set_reg(idx, val);
   endtask

   task automatic configure(input logic [7:0] magic_val, input logic [7:0] source_val);
      write_reg(REG_MAGIC, magic_val);
      write_reg(REG_SOURCE, source_val);
      csr_we <= 1'b0;
   endtask

   // receiver: check accepted frames, then pick tready from its own pattern
   initial begin
      int          hold_left;
      int          mode;
      int unsigned cyc;
      hold_left = 0;
      mode = 0;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if (cyc % 64 == 0) mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (cyc % 4 != 0);
               default: rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // watchdog: too long without any handshake means the block hung
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: noise on an empty window, extreme payload, bad CRC
      push_byte(8'h00);
      send_frame({32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h8000}, 1'b0);
      send_frame({32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'h7FFF}, 1'b1);

      // reset settings
      random_traffic(100);
      pressure_burst();
      random_traffic(130);

      // extreme settings
      drain();
      configure(8'h00, 8'hFF);
      random_traffic(170);
      drain();
      configure(8'hFF, 8'h00);
      random_traffic(130);

      // random settings
      drain();
      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_traffic(130);

      drain();
      repeat (4) @(posedge clock);
      if (board.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
